@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/mfm_pkg.sv @@
// ----------------------------------------------------------------------------
// mfm_pkg
// shared types and frame constants of the mdio management frame master
// ----------------------------------------------------------------------------
package mfm_pkg;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    localparam logic [1:0] FRAME_ST       = 2'b01;
    localparam logic [1:0] FRAME_OP_READ  = 2'b10;
    localparam logic [1:0] FRAME_OP_WRITE = 2'b01;
    localparam logic [1:0] FRAME_WRITE_TA = 2'b10;

    localparam int FRAME_TAIL_BITS = 32;
    localparam int ADDR_END_BITS   = 14;
    localparam int TA2_OFFSET      = 15;
    localparam int DATA_OFFSET     = 16;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [4:0]  phy_address;
        logic [4:0]  register_address;
        logic [15:0] write_value;
        logic        mdio_sample;
    } t_request;

    typedef struct packed {
        logic        mdc_level;
        logic        mdio_drive_value;
        logic        mdio_drive_enable;
        logic        busy_res;
        logic        frame_done;
        logic [15:0] read_value;
        logic        turnaround_error;
        logic        request_dropped;
    } t_result;

endpackage

@@ src/mfm_in_stage.sv @@
// ----------------------------------------------------------------------------
// mfm_in_stage
// input register holding one accepted tick transaction
// ----------------------------------------------------------------------------
module mfm_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mfm_pkg::t_request i_req,
    input  logic              i_out_ready,
    output logic              o_advance,
    output mfm_pkg::t_request o_req
);

    logic              r_in_valid;
    mfm_pkg::t_request r_req;
    logic              accept;

    assign o_advance  = r_in_valid && i_out_ready;
    assign o_in_stall = r_in_valid && !i_out_ready;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_req      = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (o_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
    end

endmodule

@@ src/mfm_frame_engine.sv @@
// ----------------------------------------------------------------------------
// mfm_frame_engine
// frame state, bit timing and result of one tick
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mfm_frame_engine #(
    parameter int PREAMBLE_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    input  logic              i_advance,
    input  mfm_pkg::t_request i_req,
    output mfm_pkg::t_result  o_result
);

    localparam int POS_W = $clog2(PREAMBLE_BITS + mfm_pkg::FRAME_TAIL_BITS);
    localparam logic [POS_W-1:0] PRE_POS   = POS_W'(PREAMBLE_BITS);
    localparam logic [POS_W-1:0] DRIVE_END = POS_W'(PREAMBLE_BITS + mfm_pkg::ADDR_END_BITS);
    localparam logic [POS_W-1:0] LAST_POS  =
        POS_W'(PREAMBLE_BITS + mfm_pkg::FRAME_TAIL_BITS - 1);
    localparam logic [POS_W-1:0] TA2_OFF   = POS_W'(mfm_pkg::TA2_OFFSET);
    localparam logic [POS_W-1:0] DATA_OFF  = POS_W'(mfm_pkg::DATA_OFFSET);

    logic [7:0]       r_half_period;
    logic             r_active,     n_active;
    logic             r_read_frame, n_read_frame;
    logic [POS_W-1:0] r_bit_pos,    n_bit_pos;
    logic [7:0]       r_tick_count, n_tick_count;
    logic             r_clock_high, n_clock_high;
    logic [31:0]      r_header,     n_header;
    logic [15:0]      r_captured,   n_captured;
    logic             r_ta_fault,   n_ta_fault;

    logic             start_req;
    logic             done;
    logic             dropped;
    logic [7:0]       half_eff;
    logic [7:0]       tick_inc;
    logic [POS_W-1:0] pos_off;
    logic [POS_W-1:0] out_off;
    logic             drive_en;
    logic             bit_value;

    always_comb begin
        n_active     = r_active;
        n_read_frame = r_read_frame;
        n_bit_pos    = r_bit_pos;
        n_tick_count = r_tick_count;
        n_clock_high = r_clock_high;
        n_header     = r_header;
        n_captured   = r_captured;
        n_ta_fault   = r_ta_fault;
        done         = 1'b0;
        dropped      = 1'b0;
        start_req    = (i_req.func == mfm_pkg::FUNC_READ) ||
                       (i_req.func == mfm_pkg::FUNC_WRITE);
        half_eff     = (r_half_period == 8'd0) ? 8'd1 : r_half_period;
        tick_inc     = r_tick_count + 8'd1;
        pos_off      = r_bit_pos - PRE_POS;

        if (r_active) begin
            dropped      = start_req;
            n_tick_count = tick_inc;
            if (tick_inc >= half_eff) begin
                n_tick_count = 8'd0;
                if (!r_clock_high) begin
                    // sample at the end of the low half
                    if (r_read_frame && (r_bit_pos >= DRIVE_END)) begin
                        if (pos_off == TA2_OFF) begin
                            if (i_req.mdio_sample) begin
                                n_ta_fault = 1'b1;
                            end
                        end else if (pos_off >= DATA_OFF) begin
                            n_captured = {r_captured[14:0], i_req.mdio_sample};
                        end
                    end
                    n_clock_high = 1'b1;
                end else begin
                    n_clock_high = 1'b0;
                    if (r_bit_pos == LAST_POS) begin
                        n_active  = 1'b0;
                        n_bit_pos = '0;
                        done      = 1'b1;
                    end else begin
                        n_bit_pos = r_bit_pos + POS_W'(1);
                    end
                end
            end
        end else if (start_req) begin
            n_read_frame = (i_req.func == mfm_pkg::FUNC_READ);
            if (n_read_frame) begin
                n_header   = {mfm_pkg::FRAME_ST, mfm_pkg::FRAME_OP_READ,
                              i_req.phy_address, i_req.register_address, 18'd0};
                n_captured = 16'd0;
                n_ta_fault = 1'b0;
            end else begin
                n_header   = {mfm_pkg::FRAME_ST, mfm_pkg::FRAME_OP_WRITE,
                              i_req.phy_address, i_req.register_address,
                              mfm_pkg::FRAME_WRITE_TA, i_req.write_value};
            end
            n_active     = 1'b1;
            n_bit_pos    = '0;
            n_tick_count = 8'd0;
            n_clock_high = 1'b0;
        end

        out_off   = n_bit_pos - PRE_POS;
        bit_value = (n_bit_pos < PRE_POS) ? 1'b1 : n_header[~out_off[4:0]];
        drive_en  = n_active && (!n_read_frame || (n_bit_pos < DRIVE_END));

        o_result.mdc_level         = n_active && n_clock_high;
        o_result.mdio_drive_value  = drive_en && bit_value;
        o_result.mdio_drive_enable = drive_en;
        o_result.busy_res          = n_active;
        o_result.frame_done        = done;
        o_result.read_value        = n_captured;
        o_result.turnaround_error  = n_ta_fault;
        o_result.request_dropped   = dropped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= mfm_pkg::HALF_PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_half_period <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_read_frame <= 1'b0;
            r_bit_pos    <= '0;
            r_tick_count <= 8'd0;
            r_clock_high <= 1'b0;
            r_header     <= 32'd0;
            r_captured   <= 16'd0;
            r_ta_fault   <= 1'b0;
        end else if (i_advance) begin
            r_active     <= n_active;
            r_read_frame <= n_read_frame;
            r_bit_pos    <= n_bit_pos;
            r_tick_count <= n_tick_count;
            r_clock_high <= n_clock_high;
            r_header     <= n_header;
            r_captured   <= n_captured;
            r_ta_fault   <= n_ta_fault;
        end
    end

    // idle means no bit in flight
    `ASSERT_IMPLIES(a_idle_clean, i_clk, i_rst_n, !r_active, !r_clock_high && (r_bit_pos == '0))
    // a new frame starts at bit 0, low half, first tick
    `ASSERT_IMPLIES(a_frame_start, i_clk, i_rst_n, $rose(r_active), (r_bit_pos == '0) && !r_clock_high && (r_tick_count == 8'd0))
    // write frames never touch read data
    `ASSERT_NEXT(a_write_keeps_data, i_clk, i_rst_n, r_active && !r_read_frame, $stable(r_captured) && $stable(r_ta_fault))

endmodule

@@ src/mfm_out_stage.sv @@
// ----------------------------------------------------------------------------
// mfm_out_stage
// result register toward the output channel
// ----------------------------------------------------------------------------
module mfm_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  mfm_pkg::t_result i_result,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic             o_out_ready,
    output mfm_pkg::t_result o_result
);

    logic             r_out_valid;
    mfm_pkg::t_result r_result;

    assign o_out_ready = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

@@ src/mdio_management_frame_master_unit.sv @@
// a transaction is held in the input register, then its result in the result register
// throughput: one transaction per cycle unless the output stalls, set by the input and
// result registers; the frame state steps once per transaction in one pass of logic
// reset: synchronous active low; frame idle, mdc low, line released, half period 2
// ----------------------------------------------------------------------------
// mdio_management_frame_master_unit
// clause 22 mdio master advanced by one tick transaction at a time
// ----------------------------------------------------------------------------
module mdio_management_frame_master_unit #(
    parameter int PREAMBLE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [4:0]  i_phy_address,
    input  logic [4:0]  i_register_address,
    input  logic [15:0] i_write_value,
    input  logic        i_mdio_sample,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_mdc_level,
    output logic        o_mdio_drive_value,
    output logic        o_mdio_drive_enable,
    output logic        o_busy_res,
    output logic        o_frame_done,
    output logic [15:0] o_read_value,
    output logic        o_turnaround_error,
    output logic        o_request_dropped
);

    mfm_pkg::t_request in_req;
    mfm_pkg::t_request stage_req;
    mfm_pkg::t_result  next_result;
    mfm_pkg::t_result  out_result;
    logic              advance;
    logic              out_ready;

    assign in_req.func             = i_func;
    assign in_req.phy_address      = i_phy_address;
    assign in_req.register_address = i_register_address;
    assign in_req.write_value      = i_write_value;
    assign in_req.mdio_sample      = i_mdio_sample;

    mfm_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req       (in_req),
        .i_out_ready (out_ready),
        .o_advance   (advance),
        .o_req       (stage_req)
    );

    mfm_frame_engine #(
        .PREAMBLE_BITS (PREAMBLE_BITS)
    ) u_frame_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_advance   (advance),
        .i_req       (stage_req),
        .o_result    (next_result)
    );

    mfm_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance),
        .i_result    (next_result),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_ready (out_ready),
        .o_result    (out_result)
    );

    assign o_mdc_level         = out_result.mdc_level;
    assign o_mdio_drive_value  = out_result.mdio_drive_value;
    assign o_mdio_drive_enable = out_result.mdio_drive_enable;
    assign o_busy_res          = out_result.busy_res;
    assign o_frame_done        = out_result.frame_done;
    assign o_read_value        = out_result.read_value;
    assign o_turnaround_error  = out_result.turnaround_error;
    assign o_request_dropped   = out_result.request_dropped;

endmodule
